### rtl/core/mdec_pkg.sv
// ----------------------------------------------------------------------------
// mdec_pkg: shared types and constants of the MIDI channel message decoder
// Holds the register map, message kinds, item layouts and the constants
// used by the volume scaler.
// ----------------------------------------------------------------------------
package mdec_pkg;

  // Register map of the configuration port
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_DECODE_ENABLE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ALL_CHANNELS   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LISTEN_CHANNEL = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_VEL_SENS       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RECORD_VEL     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TRANSPOSE_EN   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_TRANSPOSE_AMT  = 3'd6;

  // Reset values of the registers
  localparam logic       RST_DECODE_ENABLE  = 1'b0;
  localparam logic       RST_ALL_CHANNELS   = 1'b1;
  localparam logic [4:0] RST_LISTEN_CHANNEL = 5'd1;
  localparam logic [7:0] RST_VEL_SENS       = 8'd100;
  localparam logic       RST_RECORD_VEL     = 1'b1;
  localparam logic       RST_TRANSPOSE_EN   = 1'b0;
  localparam logic [6:0] RST_TRANSPOSE_AMT  = 7'd0;

  // Message kinds (upper nibble of the status byte)
  localparam logic [3:0] KIND_NOTE_OFF = 4'h8;
  localparam logic [3:0] KIND_NOTE_ON  = 4'h9;
  localparam logic [3:0] KIND_CTRL     = 4'hB;
  localparam logic [3:0] KIND_BEND     = 4'hE;
  localparam logic [3:0] KIND_SYSTEM   = 4'hF;

  localparam logic [6:0] CC_MOD_WHEEL = 7'd1;
  localparam logic [1:0] LEN_MIN      = 2'd2;
  localparam logic [1:0] LEN_FULL     = 2'd3;

  // Note mapping: key minus offset, kept when 1..NOTE_LIMIT-1
  localparam logic signed [8:0] NOTE_OFFSET = 9'sd11;
  localparam logic signed [8:0] NOTE_LIMIT  = 9'sd96;

  // Volume: floor(vel * sens * 64 / 12700) as (vel * sens * VOL_RECIP) >> VOL_SHIFT.
  // The reciprocal is rounded up and exact for every product below 2^15.
  localparam int unsigned     VOL_SHIFT = 27;
  localparam logic [19:0]     VOL_RECIP = 20'd676373;
  localparam logic [7:0]      VOL_MAX   = 8'd64;
  localparam logic [7:0]      VOL_MIN_ON = 8'd1;
  localparam logic [7:0]      VOL_NO_REC = 8'hFF;

  localparam logic [7:0] EFFECT_BASE = 8'hA0;
  localparam logic [7:0] PITCH_FLIP  = 8'h80;

  // Configuration registers as seen by the datapath
  typedef struct packed {
    logic            decode_enable;
    logic            all_channels;
    logic [4:0]      listen_channel;
    logic [7:0]      velocity_sensitivity;
    logic            record_velocity;
    logic            transpose_enable;
    logic signed [6:0] transpose_amount;
  } cfg_t;

  // Input item, status byte in the lowest bits
  typedef struct packed {
    logic [1:0] message_length;
    logic [7:0] second_data;
    logic [7:0] first_data;
    logic [7:0] status_byte;
  } in_item_t;

  localparam int unsigned IN_ITEM_W = $bits(in_item_t);

  // Decoded request between the decode stage and the volume stage
  typedef struct packed {
    logic        note_valid;
    logic [6:0]  note_number;
    logic        vel_nonzero;
    logic [14:0] vel_prod;
    logic        effect_valid;
    logic [7:0]  effect_param;
    logic [12:0] vibrato_word;
    logic        vibrato_changed;
    logic [7:0]  pitch_bend;
    logic        pitch_changed;
    logic        channel_match;
  } mid_item_t;

  // Result item, note_valid in the lowest bits
  typedef struct packed {
    logic              channel_match;
    logic              pitch_changed;
    logic signed [7:0] pitch_bend;
    logic              vibrato_changed;
    logic [12:0]       vibrato_word;
    logic [7:0]        effect_param;
    logic              effect_valid;
    logic signed [7:0] note_volume;
    logic [6:0]        note_number;
    logic              note_valid;
  } out_item_t;

  localparam int unsigned OUT_ITEM_W = $bits(out_item_t);

endpackage

### rtl/core/mdec_cfg.sv
// ----------------------------------------------------------------------------
// mdec_cfg: configuration register file
// Takes one write per cycle from the plain write port; unknown indexes are
// dropped.
// ----------------------------------------------------------------------------
module mdec_cfg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [mdec_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mdec_pkg::CFG_DATA_W-1:0]  cfg_data,
  output mdec_pkg::cfg_t                   cfg_o
);

  mdec_pkg::cfg_t cfg_r;
  mdec_pkg::cfg_t cfg_nxt;

  // Decode the register index
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        mdec_pkg::REG_DECODE_ENABLE:  cfg_nxt.decode_enable        = cfg_data[0];
        mdec_pkg::REG_ALL_CHANNELS:   cfg_nxt.all_channels         = cfg_data[0];
        mdec_pkg::REG_LISTEN_CHANNEL: cfg_nxt.listen_channel       = cfg_data[4:0];
        mdec_pkg::REG_VEL_SENS:       cfg_nxt.velocity_sensitivity = cfg_data[7:0];
        mdec_pkg::REG_RECORD_VEL:     cfg_nxt.record_velocity      = cfg_data[0];
        mdec_pkg::REG_TRANSPOSE_EN:   cfg_nxt.transpose_enable     = cfg_data[0];
        mdec_pkg::REG_TRANSPOSE_AMT:  cfg_nxt.transpose_amount     = $signed(cfg_data[6:0]);
        default:                      cfg_nxt = cfg_r;
      endcase
    end
  end

  // Hold the registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.decode_enable        <= mdec_pkg::RST_DECODE_ENABLE;
      cfg_r.all_channels         <= mdec_pkg::RST_ALL_CHANNELS;
      cfg_r.listen_channel       <= mdec_pkg::RST_LISTEN_CHANNEL;
      cfg_r.velocity_sensitivity <= mdec_pkg::RST_VEL_SENS;
      cfg_r.record_velocity      <= mdec_pkg::RST_RECORD_VEL;
      cfg_r.transpose_enable     <= mdec_pkg::RST_TRANSPOSE_EN;
      cfg_r.transpose_amount     <= $signed(mdec_pkg::RST_TRANSPOSE_AMT);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg_o = cfg_r;

endmodule

### rtl/core/mdec_decode.sv
// ----------------------------------------------------------------------------
// mdec_decode: message decode stage
// Classifies the message, updates the channel flag, vibrato word and pitch
// bend, maps the key to a tracker note and forms velocity times sensitivity.
// ----------------------------------------------------------------------------
module mdec_decode (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  adv_i,
  input  mdec_pkg::in_item_t    item_i,
  input  mdec_pkg::cfg_t        cfg_i,
  output mdec_pkg::mid_item_t   mid_o
);

  logic              chan_ok_r, chan_ok_nxt;
  logic [12:0]       vib_r, vib_nxt;
  logic [7:0]        pitch_r, pitch_nxt;
  mdec_pkg::mid_item_t mid_r, mid_nxt;

  logic [3:0]        kind;
  logic [6:0]        d1;
  logic [6:0]        d2;
  logic [6:0]        vel;
  logic              msg_ok;
  logic              chan_hit;
  logic signed [8:0] note;
  logic signed [8:0] shift_amt;
  logic              note_in_range;
  logic [13:0]       bend;
  logic [3:0]        depth;

  // Split and mask the message
  assign kind = item_i.status_byte[7:4];
  assign d1   = item_i.first_data[6:0];
  assign d2   = (item_i.message_length == mdec_pkg::LEN_FULL) ? item_i.second_data[6:0]
                                                              : 7'd0;
  assign msg_ok = cfg_i.decode_enable && (item_i.message_length >= mdec_pkg::LEN_MIN) &&
                  item_i.status_byte[7] && (kind != mdec_pkg::KIND_SYSTEM);
  assign chan_hit = cfg_i.all_channels ||
                    ((cfg_i.listen_channel != 5'd0) &&
                     ({1'b0, item_i.status_byte[3:0]} + 5'd1 == cfg_i.listen_channel));

  // Note path: key minus offset plus optional transpose
  assign vel       = (kind == mdec_pkg::KIND_NOTE_ON) ? d2 : 7'd0;
  assign shift_amt = cfg_i.transpose_enable ? 9'(cfg_i.transpose_amount) : 9'sd0;
  assign note      = $signed({2'b00, d1}) - mdec_pkg::NOTE_OFFSET + shift_amt;
  assign note_in_range = (note > 9'sd0) && (note < mdec_pkg::NOTE_LIMIT);

  assign bend  = {d2, d1};
  assign depth = d2[6:3];

  // Build the decoded request and the next held state
  always_comb begin
    chan_ok_nxt = chan_ok_r;
    vib_nxt     = vib_r;
    pitch_nxt   = pitch_r;
    mid_nxt     = '0;
    if (msg_ok) begin
      chan_ok_nxt = chan_hit;
      unique case (kind)
        mdec_pkg::KIND_NOTE_OFF, mdec_pkg::KIND_NOTE_ON: begin
          if (note_in_range && chan_hit) begin
            mid_nxt.note_valid  = 1'b1;
            mid_nxt.note_number = note[6:0];
            mid_nxt.vel_nonzero = (vel != 7'd0);
            mid_nxt.vel_prod    = {8'd0, vel} * {7'd0, cfg_i.velocity_sensitivity};
          end
        end
        mdec_pkg::KIND_CTRL: begin
          if (d1 == mdec_pkg::CC_MOD_WHEEL) begin
            vib_nxt                 = {d2, 6'd0};
            mid_nxt.vibrato_changed = 1'b1;
            if ((depth != 4'd0) && chan_hit) begin
              mid_nxt.effect_valid = 1'b1;
              mid_nxt.effect_param = mdec_pkg::EFFECT_BASE | {4'd0, depth};
            end
          end
        end
        mdec_pkg::KIND_BEND: begin
          pitch_nxt             = bend[13:6] ^ mdec_pkg::PITCH_FLIP;
          mid_nxt.pitch_changed = 1'b1;
        end
        default: begin
          mid_nxt.note_valid = 1'b0;
        end
      endcase
    end
    mid_nxt.vibrato_word  = vib_nxt;
    mid_nxt.pitch_bend    = pitch_nxt;
    mid_nxt.channel_match = chan_ok_nxt;
  end

  // Hold state and advance the request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chan_ok_r <= 1'b1;
      vib_r     <= '0;
      pitch_r   <= '0;
    end else if (adv_i) begin
      chan_ok_r <= chan_ok_nxt;
      vib_r     <= vib_nxt;
      pitch_r   <= pitch_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_i) begin
      mid_r <= mid_nxt;
    end
  end

  assign mid_o = mid_r;

endmodule

### rtl/core/mdec_volume.sv
// ----------------------------------------------------------------------------
// mdec_volume: volume scaling and result register
// Divides velocity times sensitivity by the constant scale through a
// reciprocal multiply, applies the cap and the note-on rules, and registers
// the result item.
// ----------------------------------------------------------------------------
module mdec_volume (
  input  logic                  clk,
  input  logic                  adv_i,
  input  logic                  record_velocity_i,
  input  mdec_pkg::mid_item_t   mid_i,
  output mdec_pkg::out_item_t   res_o
);

  logic [34:0]         scaled;
  logic [34:0]         quot_full;
  logic [7:0]          quot;
  logic [7:0]          vol;
  mdec_pkg::out_item_t res_r, res_nxt;

  // Reciprocal multiply, exact for every product in range
  assign scaled    = 35'(mid_i.vel_prod) * 35'(mdec_pkg::VOL_RECIP);
  assign quot_full = scaled >> mdec_pkg::VOL_SHIFT;
  assign quot      = quot_full[7:0];

  // Cap, force a sounding note to at least one, drop volume when not recorded
  always_comb begin
    vol = (quot > mdec_pkg::VOL_MAX) ? mdec_pkg::VOL_MAX : quot;
    if (mid_i.vel_nonzero && (vol == 8'd0)) begin
      vol = mdec_pkg::VOL_MIN_ON;
    end
    if (mid_i.vel_nonzero && !record_velocity_i) begin
      vol = mdec_pkg::VOL_NO_REC;
    end
  end

  always_comb begin
    res_nxt.note_valid      = mid_i.note_valid;
    res_nxt.note_number     = mid_i.note_number;
    res_nxt.note_volume     = mid_i.note_valid ? $signed(vol) : 8'sd0;
    res_nxt.effect_valid    = mid_i.effect_valid;
    res_nxt.effect_param    = mid_i.effect_param;
    res_nxt.vibrato_word    = mid_i.vibrato_word;
    res_nxt.vibrato_changed = mid_i.vibrato_changed;
    res_nxt.pitch_bend      = $signed(mid_i.pitch_bend);
    res_nxt.pitch_changed   = mid_i.pitch_changed;
    res_nxt.channel_match   = mid_i.channel_match;
  end

  // Load the result register
  always_ff @(posedge clk) begin
    if (adv_i) begin
      res_r <= res_nxt;
    end
  end

  assign res_o = res_r;

endmodule

### rtl/core/midi_channel_message_decoder.sv
// ----------------------------------------------------------------------------
// midi_channel_message_decoder: MIDI channel message decoder, top level
//
// One request on the in_ stream is one complete channel message; each one
// gives exactly one result on the out_ stream, in order.
// Pipeline: input register, decode stage register, result register. A taken
// request passes through these three registers in order, and its result is
// shown on out_tvalid once it reaches the result register.
// Throughput is one message per cycle while out_tready is high; the limit is
// the single decode stage, which updates the held channel flag, vibrato word
// and pitch bend as each message passes so the next message sees them at once.
// When the receiver holds out_tready low, the stages fill one by one and
// in_tready falls only once all three are full; nothing is dropped.
// The configuration port writes one register per cycle with cfg_we; write it
// only while no message is in flight.
// Reset (rst_n low, synchronous) empties the pipeline and restores the
// register defaults and the held state (channel flag set, vibrato and pitch 0).
// ----------------------------------------------------------------------------
module midi_channel_message_decoder (
  input  logic                             clk,
  input  logic                             rst_n,
  // status_byte[7:0], first_data[15:8], second_data[23:16],
  // message_length[25:24], zero fill [31:26]
  input  logic [31:0]                      in_tdata,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // note_valid[0], note_number[7:1], note_volume[15:8], effect_valid[16],
  // effect_param[24:17], vibrato_word[37:25], vibrato_changed[38],
  // pitch_bend[46:39], pitch_changed[47], channel_match[48], zero fill [55:49]
  output logic [55:0]                      out_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  input  logic                             cfg_we,
  input  logic [mdec_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mdec_pkg::CFG_DATA_W-1:0]  cfg_data
);

  mdec_pkg::cfg_t      cfg;
  mdec_pkg::in_item_t  in_r;
  mdec_pkg::mid_item_t mid;
  mdec_pkg::out_item_t res;
  mdec_pkg::out_item_t chk;

  logic v0_r, v0_nxt;
  logic v1_r, v1_nxt;
  logic v2_r, v2_nxt;
  logic rdy1, rdy2;
  logic adv0, adv1;
  logic in_acc, out_acc;

  mdec_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg_o     (cfg)
  );

  // Pipeline control: a stage moves on when the next one is free or draining
  assign rdy2      = !v2_r || out_tready;
  assign rdy1      = !v1_r || rdy2;
  assign adv1      = v1_r && rdy2;
  assign adv0      = v0_r && rdy1;
  assign in_tready = !v0_r || rdy1;
  assign in_acc    = in_tvalid && in_tready;
  assign out_acc   = v2_r && out_tready;

  always_comb begin
    v0_nxt = in_acc ? 1'b1 : (adv0 ? 1'b0 : v0_r);
    v1_nxt = adv0   ? 1'b1 : (adv1 ? 1'b0 : v1_r);
    v2_nxt = adv1   ? 1'b1 : (out_acc ? 1'b0 : v2_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v0_r <= v0_nxt;
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
    end
  end

  // Capture the request
  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_r <= mdec_pkg::in_item_t'(in_tdata[mdec_pkg::IN_ITEM_W-1:0]);
    end
  end

  mdec_decode u_decode (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv_i  (adv0),
    .item_i (in_r),
    .cfg_i  (cfg),
    .mid_o  (mid)
  );

  mdec_volume u_volume (
    .clk               (clk),
    .adv_i             (adv1),
    .record_velocity_i (cfg.record_velocity),
    .mid_i             (mid),
    .res_o             (res)
  );

  assign out_tvalid = v2_r;
  assign out_tdata  = {7'd0, res};

  assign chk = mdec_pkg::out_item_t'(out_tdata[mdec_pkg::OUT_ITEM_W-1:0]);

  // A reported note lies in the tracker range
  a_note_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && chk.note_valid) |-> (chk.note_number != 7'd0 && chk.note_number < 7'd96))
    else $error("note number out of range");

  // Volume is minus one or within 0..64, and zero when no note
  a_vol_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((chk.note_volume == -8'sd1 || (chk.note_volume >= 8'sd0 &&
                     chk.note_volume <= 8'sd64)) && (chk.note_valid || chk.note_volume == 8'sd0)))
    else $error("note volume out of range");

  // An effect request is always vibrato with a nonzero depth from a wheel move
  a_effect: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && chk.effect_valid) |->
      (chk.effect_param[7:4] == 4'hA && chk.effect_param[3:0] != 4'd0 && chk.vibrato_changed))
    else $error("bad effect request");

  // One message does not change both the vibrato word and the pitch bend
  a_one_update: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(chk.vibrato_changed && chk.pitch_changed))
    else $error("vibrato and pitch both changed");

  // A full input stage that takes a new request must hand its item on
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && v0_r) |-> (adv0 && (!v1_r || adv1)))
    else $error("pipeline overrun");

endmodule
